// ===== src/kmst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_pkg
// Shared types and constants of the minimum spanning tree core.
// ----------------------------------------------------------------------------
package kmst_pkg;

    localparam int MAX_EDGES    = 64;
    localparam int MAX_VERTICES = 16;
    localparam int EIDX_W       = $clog2(MAX_EDGES);
    localparam int ECNT_W       = $clog2(MAX_EDGES + 1);
    localparam int VTX_W        = 4;
    localparam int WGT_W        = 16;
    localparam int COST_W       = 20;
    localparam int EDGE_W       = 2 * VTX_W + WGT_W;
    localparam int MAX_TREE     = MAX_VERTICES - 1;

    // controller to datapath
    typedef struct packed {
        logic store;      // write input edge at count
        logic clr_parent; // mark all vertices as root
        logic rd_i;       // read edge at index i
        logic rd_j;       // read edge at index j-1 (sort compare)
        logic latch_key;  // key <- read data
        logic shift;      // mem[j] <- read data
        logic place;      // mem[j] <- key
        logic ld_edge;    // walk edge <- read data, roots start at endpoints
        logic find_step;  // one parent hop on both endpoints
        logic take;       // link roots, add cost, hold word, release previous
        logic empty_out;  // load empty-tree result
        logic set_last;   // release held word marked last
        logic finish;     // clear count and cost
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic gt;        // weight(mem[j-1]) > weight(key)
        logic roots_done;
        logic same_root;
        logic vtx_bad;
        logic out_busy;
    } t_sts;

endpackage

// ===== src/kmst_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_datapath
// Edge memory, sort registers, union-find store, cost and output register.
// ----------------------------------------------------------------------------
module kmst_datapath
    import kmst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [EIDX_W-1:0] i_i,
    input  logic [EIDX_W-1:0] i_j,
    input  logic [VTX_W-1:0]  i_from,
    input  logic [VTX_W-1:0]  i_to,
    input  logic [WGT_W-1:0]  i_wgt,
    input  logic              i_out_ready,
    output t_sts              o_sts,
    output logic [ECNT_W-1:0] o_count,
    output logic              o_out_valid,
    output logic [31:0]       o_out_data,
    output logic              o_out_last
);

    logic [EDGE_W-1:0] r_mem [MAX_EDGES];
    logic [EDGE_W-1:0] r_rd;
    logic [EDGE_W-1:0] r_key;
    logic [ECNT_W-1:0] r_count;
    logic [VTX_W:0]    r_parent [MAX_VERTICES];
    logic [VTX_W-1:0]  r_ea, r_eb, r_ra, r_rb;
    logic [WGT_W-1:0]  r_ew;
    logic [COST_W-1:0] r_cost;
    logic              r_ov, r_olast;
    logic [31:0]       r_odata;
    logic              r_pv;
    logic [COST_W+2*VTX_W:0] r_pdata;
    logic [COST_W-1:0] n_cost;
    logic              w_ra_root, w_rb_root;

    // edge memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !o_sts.full) begin
            r_mem[r_count[EIDX_W-1:0]] <= {i_from, i_to, i_wgt};
        end else if (i_cmd.shift) begin
            r_mem[i_j] <= r_rd;
        end else if (i_cmd.place) begin
            r_mem[i_j] <= r_key;
        end
        if (i_cmd.rd_i) begin
            r_rd <= r_mem[i_i];
        end else if (i_cmd.rd_j) begin
            r_rd <= r_mem[i_j - 1'b1];
        end
    end

    assign w_ra_root = r_parent[r_ra][VTX_W];
    assign w_rb_root = r_parent[r_rb][VTX_W];
    assign n_cost    = r_cost + COST_W'(r_ew);

    // control registers and union-find
    // a tree word is held until the next take or the end of the walk,
    // so the final one can carry the last mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cost  <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
            for (int k = 0; k < MAX_VERTICES; k++) r_parent[k] <= {1'b1, {VTX_W{1'b0}}};
        end else begin
            if (i_cmd.store && !o_sts.full) r_count <= r_count + 1'b1;
            if (i_cmd.clr_parent) begin
                for (int k = 0; k < MAX_VERTICES; k++)
                    r_parent[k] <= {1'b1, {VTX_W{1'b0}}};
            end
            if (i_cmd.take) begin
                r_parent[r_ra] <= {1'b0, r_rb};
                r_cost         <= n_cost;
                r_pv           <= 1'b1;
            end else if (i_cmd.set_last) begin
                r_pv <= 1'b0;
            end
            if ((i_cmd.take && r_pv) || i_cmd.set_last || i_cmd.empty_out) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_count <= '0;
                r_cost  <= '0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_key) r_key <= r_rd;
        if (i_cmd.ld_edge) begin
            r_ea <= r_rd[EDGE_W-1 -: VTX_W];
            r_eb <= r_rd[WGT_W +: VTX_W];
            r_ra <= r_rd[EDGE_W-1 -: VTX_W];
            r_rb <= r_rd[WGT_W +: VTX_W];
            r_ew <= r_rd[WGT_W-1:0];
        end else if (i_cmd.find_step) begin
            if (!w_ra_root) r_ra <= r_parent[r_ra][VTX_W-1:0];
            if (!w_rb_root) r_rb <= r_parent[r_rb][VTX_W-1:0];
        end
        if (i_cmd.take) r_pdata <= {n_cost, r_eb, r_ea, 1'b1};
        if (i_cmd.take && r_pv) begin
            r_odata <= {3'b000, r_pdata};
            r_olast <= 1'b0;
        end else if (i_cmd.empty_out) begin
            r_odata <= '0;
            r_olast <= 1'b1;
        end else if (i_cmd.set_last) begin
            r_odata <= {3'b000, r_pdata};
            r_olast <= 1'b1;
        end
    end

    assign o_sts.full       = (r_count == ECNT_W'(MAX_EDGES));
    assign o_sts.gt         = r_rd[WGT_W-1:0] > r_key[WGT_W-1:0];
    assign o_sts.roots_done = w_ra_root && w_rb_root;
    assign o_sts.same_root  = (r_ra == r_rb);
    assign o_sts.vtx_bad    = (32'(r_ea) >= MAX_VERTICES) || (32'(r_eb) >= MAX_VERTICES);
    assign o_sts.out_busy   = r_ov;
    assign o_count          = r_count;
    assign o_out_valid      = r_ov;
    assign o_out_data       = r_odata;
    assign o_out_last       = r_olast;

endmodule

// ===== src/kmst_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmst_ctrl
// Sequencer: load, insertion sort, union-find walk, result hand-off.
// ----------------------------------------------------------------------------
module kmst_ctrl
    import kmst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    input  t_sts              i_sts,
    input  logic [ECNT_W-1:0] i_count,
    output t_cmd              o_cmd,
    output logic [EIDX_W-1:0] o_i,
    output logic [EIDX_W-1:0] o_j
);

    typedef enum logic [3:0] {
        S_LOAD, S_SRD, S_SKEY, S_SCMP, S_SCHK, S_SPLACE,
        S_WRD, S_WLD, S_WFIND, S_WDEC, S_END, S_DRAIN
    } t_state;

    t_state            r_state, n_state;
    logic [ECNT_W-1:0] r_i, n_i;
    logic [EIDX_W-1:0] r_j, n_j;
    logic [VTX_W-1:0]  r_n, n_n;
    logic [VTX_W:0]    r_hops, n_hops;
    logic              w_free;
    t_cmd              c;

    assign w_free = !i_sts.out_busy || i_out_ready;

    // next state and commands
    always_comb begin
        c       = '0;
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_n     = r_n;
        n_hops  = r_hops;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    c.store = 1'b1;
                    if (i_in_last) begin
                        n_i     = ECNT_W'(1);
                        n_state = S_SRD;
                    end
                end
            end
            S_SRD: begin
                if (r_i >= i_count) begin
                    c.clr_parent = 1'b1;
                    n_i          = '0;
                    n_n          = '0;
                    n_state      = S_WRD;
                end else begin
                    c.rd_i  = 1'b1;
                    n_j     = r_i[EIDX_W-1:0];
                    n_state = S_SKEY;
                end
            end
            S_SKEY: begin
                c.latch_key = 1'b1;
                n_state     = S_SCHK;
            end
            S_SCHK: begin
                if (r_j == '0) n_state = S_SPLACE;
                else begin
                    c.rd_j  = 1'b1;
                    n_state = S_SCMP;
                end
            end
            S_SCMP: begin
                if (i_sts.gt) begin
                    c.shift = 1'b1;
                    n_j     = r_j - 1'b1;
                    n_state = S_SCHK;
                end else n_state = S_SPLACE;
            end
            S_SPLACE: begin
                c.place = 1'b1;
                n_i     = r_i + 1'b1;
                n_state = S_SRD;
            end
            S_WRD: begin
                if (r_i >= i_count || r_n == VTX_W'(MAX_TREE)) n_state = S_END;
                else begin
                    c.rd_i  = 1'b1;
                    n_state = S_WLD;
                end
            end
            S_WLD: begin
                c.ld_edge = 1'b1;
                n_hops    = '0;
                n_state   = S_WFIND;
            end
            S_WFIND: begin
                if (i_sts.vtx_bad) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_WRD;
                end else if (!i_sts.roots_done && r_hops != (VTX_W+1)'(MAX_VERTICES)) begin
                    c.find_step = 1'b1;
                    n_hops      = r_hops + 1'b1;
                end else n_state = S_WDEC;
            end
            S_WDEC: begin
                if (i_sts.same_root) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_WRD;
                end else if (w_free) begin
                    c.take  = 1'b1;
                    n_n     = r_n + 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = S_WRD;
                end
            end
            S_END: begin
                if (w_free) begin
                    if (r_n == '0) c.empty_out = 1'b1;
                    else c.set_last = 1'b1;
                    c.finish = 1'b1;
                    n_state  = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.out_busy || i_out_ready) n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_i     <= '0;
            r_j     <= '0;
            r_n     <= '0;
            r_hops  <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_n     <= n_n;
            r_hops  <= n_hops;
        end
    end

    assign o_cmd      = c;
    assign o_in_ready = (r_state == S_LOAD);
    assign o_i        = r_i[EIDX_W-1:0];
    assign o_j        = r_j;

    // index reads (sort and walk) never go beyond the stored edges
    a_rd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c.rd_i |-> (ECNT_W'(r_i) < i_count)) else $error("read past edge count");
    // tree edge count bounded
    a_tree_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= VTX_W'(MAX_TREE)) else $error("too many tree edges");
    // input only taken while loading
    a_load_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c.store |-> (r_state == S_LOAD)) else $error("store outside load");
endmodule

// ===== src/kruskal_min_spanning_tree_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kruskal_min_spanning_tree_core
// Minimum spanning tree over a loaded edge list.
// ----------------------------------------------------------------------------
// Edges are taken one word a cycle while loading. The last word starts the run:
// an in-place insertion sort over the edge memory (quadratic in edge count, one
// memory port), then a walk of the sorted list with a union-find search per edge.
// Each tree word is held until the next tree edge or the end of the walk, so it
// goes out one take late and the final one carries tlast. Input is refused from
// the last word until the final result is taken.
module kruskal_min_spanning_tree_core
    import kmst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // from_vertex[3:0], to_vertex[7:4], weight[23:8]
    input  logic        s_axis_tlast,  // last_edge
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // has_edge[0], tree_from[4:1], tree_to[8:5],
                                       // total_cost[28:9], zero pad
    output logic        m_axis_tlast   // last_result
);

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [ECNT_W-1:0] w_count;
    logic [EIDX_W-1:0] w_i, w_j;

    kmst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_out_ready(m_axis_tready),
        .i_sts      (w_sts),
        .i_count    (w_count),
        .o_cmd      (w_cmd),
        .o_i        (w_i),
        .o_j        (w_j)
    );

    kmst_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_i        (w_i),
        .i_j        (w_j),
        .i_from     (s_axis_tdata[3:0]),
        .i_to       (s_axis_tdata[7:4]),
        .i_wgt      (s_axis_tdata[23:8]),
        .i_out_ready(m_axis_tready),
        .o_sts      (w_sts),
        .o_count    (w_count),
        .o_out_valid(m_axis_tvalid),
        .o_out_data (m_axis_tdata),
        .o_out_last (m_axis_tlast)
    );

endmodule
